[rtl/rtd_pkg.sv]
package rtd_pkg;

  // Coordinate format and the width of the saturated intermediate values.
  localparam int CoordW = 24;
  localparam int FracW  = 20;
  localparam int ImmW   = 32;

  // Exact products are rounded in a word wide enough for any of them.
  localparam int WideW  = 2 * ImmW + 2;
  // Rounded coefficient-times-intermediate terms.
  localparam int KrW    = CoordW + ImmW - FracW + 2;
  localparam int SumW   = KrW + 2;

  // Stages in the whole pipe, and those of them in the term stage group.
  localparam int TermStages = 9;
  localparam int NumStages  = TermStages + 2;

  localparam int NumRegs = 5;
  localparam int CfgIdxW = $clog2(NumRegs);

  typedef logic signed [CoordW-1:0]      coord_t;
  typedef logic signed [ImmW-1:0]        imm_t;
  typedef logic signed [WideW-1:0]       wide_t;
  typedef logic signed [KrW-1:0]         kr_t;
  typedef logic signed [SumW-1:0]        sum_t;
  typedef logic signed [2*CoordW-1:0]    pcc_t;
  typedef logic signed [CoordW+ImmW-1:0] pci_t;
  typedef logic signed [2*ImmW-1:0]      pii_t;
  typedef logic [CfgIdxW-1:0]            cfg_idx_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegK1,
    RegK2,
    RegK3,
    RegP1,
    RegP2
  } cfg_reg_t;

  typedef struct packed {
    coord_t k1;
    coord_t k2;
    coord_t k3;
    coord_t p1;
    coord_t p2;
  } coef_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } pipe_ctl_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    imm_t   scale;
    kr_t    tanx;
    kr_t    tany;
  } terms_t;

  typedef struct packed {
    coord_t value;
    logic   hit;
  } sat_coord_t;

  localparam wide_t ImmMax   = (wide_t'(1) <<< (ImmW - 1)) - wide_t'(1);
  localparam wide_t ImmMin   = -ImmMax - wide_t'(1);
  localparam wide_t CoordMax = (wide_t'(1) <<< (CoordW - 1)) - wide_t'(1);
  localparam wide_t CoordMin = -CoordMax - wide_t'(1);
  localparam sum_t  OneQ     = sum_t'(1) <<< FracW;

  // Round to nearest with ties upwards, dropping FracW fraction bits.
  function automatic wide_t rnd_q(input wide_t v);
    return (v + (wide_t'(1) <<< (FracW - 1))) >>> FracW;
  endfunction

  // The same, dropping one bit fewer: gives the doubled product.
  function automatic wide_t rnd_q2(input wide_t v);
    return (v + (wide_t'(1) <<< (FracW - 2))) >>> (FracW - 1);
  endfunction

  function automatic imm_t sat_imm(input wide_t v);
    wide_t r;
    if (v > ImmMax) begin
      r = ImmMax;
    end else if (v < ImmMin) begin
      r = ImmMin;
    end else begin
      r = v;
    end
    return imm_t'(r);
  endfunction

  function automatic sat_coord_t sat_coord(input wide_t v);
    sat_coord_t s;
    if (v > CoordMax) begin
      s.value = coord_t'(CoordMax);
      s.hit   = 1'b1;
    end else if (v < CoordMin) begin
      s.value = coord_t'(CoordMin);
      s.hit   = 1'b1;
    end else begin
      s.value = coord_t'(v);
      s.hit   = 1'b0;
    end
    return s;
  endfunction

endpackage

[rtl/rtd_if.sv]
interface rtd_point_if;
  logic                 valid;
  logic                 ready;
  rtd_pkg::coord_t      x_in;
  rtd_pkg::coord_t      y_in;

  modport source (output valid, output x_in, output y_in, input ready);
  modport sink (input valid, input x_in, input y_in, output ready);
endinterface

interface rtd_result_if;
  logic                 valid;
  logic                 ready;
  rtd_pkg::coord_t      x_out;
  rtd_pkg::coord_t      y_out;
  logic                 clipped;

  modport source (output valid, output x_out, output y_out, output clipped, input ready);
  modport sink (input valid, input x_out, input y_out, input clipped, output ready);
endinterface

interface rtd_cfg_if;
  logic                 valid;
  logic                 ready;
  rtd_pkg::cfg_idx_t    index;
  rtd_pkg::coord_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/rtd_cfg_regs.sv]
module rtd_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  input  rtd_pkg::cfg_idx_t  wr_index,
  input  rtd_pkg::coord_t    wr_data,
  output rtd_pkg::coef_t     coef
);

  // Indexes past the last register write nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_valid) begin
      unique case (rtd_pkg::cfg_reg_t'(wr_index))
        rtd_pkg::RegK1: coef.k1 <= wr_data;
        rtd_pkg::RegK2: coef.k2 <= wr_data;
        rtd_pkg::RegK3: coef.k3 <= wr_data;
        rtd_pkg::RegP1: coef.p1 <= wr_data;
        rtd_pkg::RegP2: coef.p2 <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/rtd_pipe_ctrl.sv]
module rtd_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output rtd_pkg::pipe_ctl_t  ctl
);

  logic [rtd_pkg::NumStages-1:0] valid;
  logic [rtd_pkg::NumStages-1:0] load;
  logic [rtd_pkg::NumStages-1:0] down_ready;

  // A stage loads when it is empty or its contents move on, so bubbles close up.
  always_comb begin
    down_ready[rtd_pkg::NumStages-1] = out_ready;
    load[rtd_pkg::NumStages-1] = !valid[rtd_pkg::NumStages-1] || out_ready;
    for (int i = rtd_pkg::NumStages - 2; i >= 0; i--) begin
      down_ready[i] = load[i+1];
      load[i] = !valid[i] || down_ready[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < rtd_pkg::NumStages; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid;

endmodule

[rtl/rtd_terms.sv]
module rtd_terms (
  input  logic                clk,
  input  rtd_pkg::pipe_ctl_t  ctl,
  input  rtd_pkg::coord_t     x_in,
  input  rtd_pkg::coord_t     y_in,
  input  rtd_pkg::coef_t      coef,
  output rtd_pkg::terms_t     terms
);

  rtd_pkg::coord_t k1, k2, k3, p1, p2;

  // Stage 0: squares and cross product, exact.
  rtd_pkg::pcc_t   pxx0, pyy0, pxy0;
  rtd_pkg::coord_t x0, y0;
  // Stage 1: rounded and saturated.
  rtd_pkg::imm_t   xx1, yy1, xy1;
  rtd_pkg::coord_t x1, y1;
  // Stage 2: r2.
  rtd_pkg::imm_t   r2_2, xx2, yy2, xy2;
  rtd_pkg::coord_t x2, y2;
  // Stage 3: r2 squared, k1 term, tangential sums.
  rtd_pkg::pii_t   pr4_3;
  rtd_pkg::pci_t   pk1_3;
  rtd_pkg::imm_t   tx3, ty3, r2_3, xy3;
  rtd_pkg::coord_t x3, y3;
  // Stage 4: r4, tangential products.
  rtd_pkg::imm_t   r4_4, r2_4;
  rtd_pkg::kr_t    k1r2_4;
  rtd_pkg::pci_t   pax4, pbx4, pay4, pby4;
  rtd_pkg::coord_t x4, y4;
  // Stage 5: r6 and k2 products, tangential terms.
  rtd_pkg::pii_t   pr6_5;
  rtd_pkg::pci_t   pk2_5;
  rtd_pkg::kr_t    k1r2_5, tanx5, tany5;
  rtd_pkg::coord_t x5, y5;
  // Stage 6
  rtd_pkg::imm_t   r6_6;
  rtd_pkg::kr_t    k1r2_6, k2r4_6, tanx6, tany6;
  rtd_pkg::coord_t x6, y6;
  // Stage 7
  rtd_pkg::pci_t   pk3_7;
  rtd_pkg::sum_t   ksum7;
  rtd_pkg::kr_t    tanx7, tany7;
  rtd_pkg::coord_t x7, y7;
  // Stage 8: radial scale.
  rtd_pkg::imm_t   scale8;
  rtd_pkg::kr_t    tanx8, tany8;
  rtd_pkg::coord_t x8, y8;

  assign k1 = coef.k1;
  assign k2 = coef.k2;
  assign k3 = coef.k3;
  assign p1 = coef.p1;
  assign p2 = coef.p2;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      pxx0 <= x_in * x_in;
      pyy0 <= y_in * y_in;
      pxy0 <= x_in * y_in;
      x0   <= x_in;
      y0   <= y_in;
    end
    if (ctl.load[1]) begin
      xx1 <= rtd_pkg::sat_imm(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pxx0)));
      yy1 <= rtd_pkg::sat_imm(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pyy0)));
      xy1 <= rtd_pkg::sat_imm(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pxy0)));
      x1  <= x0;
      y1  <= y0;
    end
    if (ctl.load[2]) begin
      r2_2 <= rtd_pkg::sat_imm(rtd_pkg::wide_t'(xx1) + rtd_pkg::wide_t'(yy1));
      xx2  <= xx1;
      yy2  <= yy1;
      xy2  <= xy1;
      x2   <= x1;
      y2   <= y1;
    end
    if (ctl.load[3]) begin
      pr4_3 <= r2_2 * r2_2;
      pk1_3 <= k1 * r2_2;
      tx3   <= rtd_pkg::sat_imm(rtd_pkg::wide_t'(r2_2) + (rtd_pkg::wide_t'(xx2) <<< 1));
      ty3   <= rtd_pkg::sat_imm(rtd_pkg::wide_t'(r2_2) + (rtd_pkg::wide_t'(yy2) <<< 1));
      r2_3  <= r2_2;
      xy3   <= xy2;
      x3    <= x2;
      y3    <= y2;
    end
    if (ctl.load[4]) begin
      r4_4   <= rtd_pkg::sat_imm(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pr4_3)));
      k1r2_4 <= rtd_pkg::kr_t'(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pk1_3)));
      pax4   <= p1 * xy3;
      pbx4   <= p2 * tx3;
      pay4   <= p2 * xy3;
      pby4   <= p1 * ty3;
      r2_4   <= r2_3;
      x4     <= x3;
      y4     <= y3;
    end
    if (ctl.load[5]) begin
      pr6_5  <= r4_4 * r2_4;
      pk2_5  <= k2 * r4_4;
      tanx5  <= rtd_pkg::kr_t'(rtd_pkg::rnd_q2(rtd_pkg::wide_t'(pax4))
                               + rtd_pkg::rnd_q(rtd_pkg::wide_t'(pbx4)));
      tany5  <= rtd_pkg::kr_t'(rtd_pkg::rnd_q2(rtd_pkg::wide_t'(pay4))
                               + rtd_pkg::rnd_q(rtd_pkg::wide_t'(pby4)));
      k1r2_5 <= k1r2_4;
      x5     <= x4;
      y5     <= y4;
    end
    if (ctl.load[6]) begin
      r6_6   <= rtd_pkg::sat_imm(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pr6_5)));
      k2r4_6 <= rtd_pkg::kr_t'(rtd_pkg::rnd_q(rtd_pkg::wide_t'(pk2_5)));
      k1r2_6 <= k1r2_5;
      tanx6  <= tanx5;
      tany6  <= tany5;
      x6     <= x5;
      y6     <= y5;
    end
    if (ctl.load[7]) begin
      pk3_7 <= k3 * r6_6;
      ksum7 <= rtd_pkg::OneQ + rtd_pkg::sum_t'(k1r2_6) + rtd_pkg::sum_t'(k2r4_6);
      tanx7 <= tanx6;
      tany7 <= tany6;
      x7    <= x6;
      y7    <= y6;
    end
    if (ctl.load[8]) begin
      scale8 <= rtd_pkg::sat_imm(rtd_pkg::wide_t'(ksum7)
                                 + rtd_pkg::rnd_q(rtd_pkg::wide_t'(pk3_7)));
      tanx8  <= tanx7;
      tany8  <= tany7;
      x8     <= x7;
      y8     <= y7;
    end
  end

  assign terms.x     = x8;
  assign terms.y     = y8;
  assign terms.scale = scale8;
  assign terms.tanx  = tanx8;
  assign terms.tany  = tany8;

endmodule

[rtl/rtd_apply.sv]
module rtd_apply (
  input  logic                clk,
  input  rtd_pkg::pipe_ctl_t  ctl,
  input  rtd_pkg::terms_t     terms,
  output rtd_pkg::coord_t     x_out,
  output rtd_pkg::coord_t     y_out,
  output logic                clipped
);

  localparam int SMul = rtd_pkg::TermStages;
  localparam int SOut = rtd_pkg::TermStages + 1;

  rtd_pkg::coord_t    tx, ty;
  rtd_pkg::imm_t      tscale;
  rtd_pkg::pci_t      psx, psy;
  rtd_pkg::kr_t       tanx, tany;
  rtd_pkg::sat_coord_t sx, sy;

  assign tx     = terms.x;
  assign ty     = terms.y;
  assign tscale = terms.scale;

  // Final sum of the scaled coordinate and the tangential term, then clamp.
  always_comb begin
    sx = rtd_pkg::sat_coord(rtd_pkg::rnd_q(rtd_pkg::wide_t'(psx)) + rtd_pkg::wide_t'(tanx));
    sy = rtd_pkg::sat_coord(rtd_pkg::rnd_q(rtd_pkg::wide_t'(psy)) + rtd_pkg::wide_t'(tany));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[SMul]) begin
      psx  <= tx * tscale;
      psy  <= ty * tscale;
      tanx <= terms.tanx;
      tany <= terms.tany;
    end
    if (ctl.load[SOut]) begin
      x_out   <= sx.value;
      y_out   <= sy.value;
      clipped <= sx.hit | sy.hit;
    end
  end

endmodule

[rtl/radial_tangential_distortion.sv]
// Radial-tangential lens distortion. Each transfer on the point channel carries one
// undistorted normalised point (x_in, y_in) in signed Q3.20 and gives exactly one
// transfer on the result channel with the distorted point, computed as
// x*s + 2*p1*x*y + p2*(r2 + 2*x*x) and y*s + 2*p2*x*y + p1*(r2 + 2*y*y), where
// r2 = x*x + y*y and s = 1 + k1*r2 + k2*r2^2 + k3*r2^3. Results outside the
// 24-bit range are clamped and flagged on clipped; intermediate values are held
// in 32 bits with saturation. The block takes one point every clock while the result
// side keeps up; its depth is set by the chain x*x, r2, r2^2, r2^3, k3*r2^3 and
// x*s: each of these multiplications has one stage for the exact product and one
// for the rounding that follows, and the sum r2 has a stage of its own. With all
// coefficients at their reset value of zero, points pass through unchanged.
module radial_tangential_distortion (
  input  logic           clk,
  input  logic           rst,
  rtd_point_if.sink      point,
  rtd_result_if.source   result,
  rtd_cfg_if.sink        cfg
);

  rtd_pkg::coef_t     coef;
  rtd_pkg::pipe_ctl_t ctl;
  rtd_pkg::terms_t    terms;

  // Coefficient writes are taken in every cycle outside reset. The user must write
  // only while the pipe is empty, as stages read them directly. It is not enforced.
  assign cfg.ready = !rst;

  rtd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .coef     (coef)
  );

  // Valid bits and per-stage load enables. A stage loads whenever it is empty
  // or the stage after it is loading, so the pipe keeps accepting points while
  // a result waits in the output stage, up to the number of empty stages.
  rtd_pipe_ctrl u_pipe_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point.valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  // No point is taken while reset is held.
  assign point.ready  = ctl.load[0] && !rst;
  assign result.valid = ctl.valid[rtd_pkg::NumStages-1];

  // Squares, r2, its powers, the radial scale and the tangential terms.
  rtd_terms u_terms (
    .clk   (clk),
    .ctl   (ctl),
    .x_in  (point.x_in),
    .y_in  (point.y_in),
    .coef  (coef),
    .terms (terms)
  );

  // Scaling of the coordinates, final sum and output clamping. The last stage
  // of this unit is the output register of the block.
  rtd_apply u_apply (
    .clk     (clk),
    .ctl     (ctl),
    .terms   (terms),
    .x_out   (result.x_out),
    .y_out   (result.y_out),
    .clipped (result.clipped)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import rtd_pkg::*;

  // Handshake pacing. Each side waits between none and GapMax cycles before
  // every transfer, whenever idling is switched on for that side.
  localparam int GapMax = 18;
  // The long hold-off of the result side, in cycles, that lets the pipe fill.
  localparam int HoldCycles = 300;
  // Cycles allowed after the last expected result before the coefficients
  // are touched, or before the run is wound up.
  localparam int DrainCycles = NumStages + 4;
  // Cycles without any transfer after which the run is declared hung.
  localparam int WatchdogLimit = 4000;
  localparam int NumPhases = 6;
  localparam int PhaseItems = 118;
  localparam int MaxReports = 10;

  localparam coord_t CoordTop    = {1'b0, {(CoordW - 1){1'b1}}};
  localparam coord_t CoordBottom = {1'b1, {(CoordW - 1){1'b0}}};
  localparam int     UnitInt     = 1 << FracW;
  localparam coord_t UnitQ       = coord_t'(UnitInt);

  // Limits of the 32-bit intermediates and of the output coordinates.
  localparam longint ImmHi = (longint'(1) <<< (ImmW - 1)) - 1;
  localparam longint ImmLo = -ImmHi - 1;
  localparam longint OutHi = (longint'(1) <<< (CoordW - 1)) - 1;
  localparam longint OutLo = -OutHi - 1;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

  // Coefficient sets that the directed part steps through.
  typedef enum int {
    SetReset,
    SetK1Top,
    SetAllTop,
    SetAllBottom,
    SetLens,
    SetThreeTerm
  } coef_set_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   clip;
  } point_out_t;

  // What the point side knows about an item when it offers it: either a result
  // that can be stated outright, or nothing, in which case the predictor decides.
  typedef struct packed {
    logic       typed;
    point_out_t want;
  } point_note_t;

  typedef struct packed {
    coef_set_t set;
    coord_t    x;
    coord_t    y;
    logic      typed;
    coord_t    wx;
    coord_t    wy;
    logic      wclip;
  } dir_row_t;

  logic clk;
  logic rst;

  rtd_point_if  point_ch ();
  rtd_result_if result_ch ();
  rtd_cfg_if    cfg_ch ();

  radial_tangential_distortion dut (
    .clk    (clk),
    .rst    (rst),
    .point  (point_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // The testbench's own copy of the coefficient registers, updated on every
  // configuration transfer, exactly as the block should update its own.
  coord_t lens_coef [NumRegs] = '{default: '0};

  point_note_t point_notes [$];
  point_out_t  pending_points [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  idle_mode_t  idle_mode = IdleBoth;
  logic        hold_request = 1'b0;

  coef_t coef_sets [6] = '{
    '{default: '0},
    '{k1: CoordTop, default: '0},
    '{k1: CoordTop, k2: CoordTop, k3: CoordTop, p1: CoordTop, p2: CoordTop},
    '{k1: CoordBottom, k2: CoordBottom, k3: CoordBottom, p1: CoordBottom,
      p2: CoordBottom},
    // A typical wide-angle lens: barrel distortion with small decentring.
    '{k1: coord_t'(-293601), k2: coord_t'(73400), k3: coord_t'(-5243),
      p1: coord_t'(1258), p2: coord_t'(-734)},
    // The three-coefficient form, pushed to its extremes.
    '{k1: CoordBottom, k2: '0, k3: '0, p1: CoordTop, p2: CoordBottom}
  };

  // Directed stimulus. Where the result is obvious it is written out: with all
  // coefficients at zero the point passes through unchanged, and a huge k1
  // drives an on-axis point into saturation with the clip flag raised, while the
  // origin stays at zero. All other rows are left to the predictor.
  dir_row_t dir_rows [25] = '{
    '{SetReset, '0, '0, 1'b1, '0, '0, 1'b0},
    '{SetReset, CoordTop, CoordTop, 1'b1, CoordTop, CoordTop, 1'b0},
    '{SetReset, CoordBottom, CoordBottom, 1'b1, CoordBottom, CoordBottom, 1'b0},
    '{SetReset, CoordTop, CoordBottom, 1'b1, CoordTop, CoordBottom, 1'b0},
    '{SetReset, CoordBottom, CoordTop, 1'b1, CoordBottom, CoordTop, 1'b0},
    '{SetReset, coord_t'(1), coord_t'(-1), 1'b1, coord_t'(1), coord_t'(-1), 1'b0},
    '{SetReset, UnitQ, coord_t'(-UnitInt), 1'b1, UnitQ, coord_t'(-UnitInt), 1'b0},
    '{SetK1Top, CoordTop, '0, 1'b1, CoordTop, '0, 1'b1},
    '{SetK1Top, CoordBottom, '0, 1'b1, CoordBottom, '0, 1'b1},
    '{SetK1Top, '0, '0, 1'b1, '0, '0, 1'b0},
    '{SetAllTop, CoordTop, CoordTop, 1'b0, '0, '0, 1'b0},
    '{SetAllTop, CoordBottom, CoordBottom, 1'b0, '0, '0, 1'b0},
    '{SetAllTop, CoordTop, CoordBottom, 1'b0, '0, '0, 1'b0},
    '{SetAllTop, '0, '0, 1'b0, '0, '0, 1'b0},
    '{SetAllTop, coord_t'(1), coord_t'(1), 1'b0, '0, '0, 1'b0},
    '{SetAllBottom, CoordBottom, CoordTop, 1'b0, '0, '0, 1'b0},
    '{SetAllBottom, CoordTop, CoordTop, 1'b0, '0, '0, 1'b0},
    '{SetAllBottom, '0, CoordBottom, 1'b0, '0, '0, 1'b0},
    '{SetAllBottom, coord_t'(-1), coord_t'(1), 1'b0, '0, '0, 1'b0},
    '{SetLens, coord_t'(UnitInt / 2), coord_t'(3 * UnitInt / 8), 1'b0, '0, '0, 1'b0},
    '{SetLens, coord_t'(-3 * UnitInt / 4), coord_t'(UnitInt / 4), 1'b0, '0, '0, 1'b0},
    '{SetLens, UnitQ, coord_t'(-UnitInt), 1'b0, '0, '0, 1'b0},
    '{SetLens, CoordBottom, CoordTop, 1'b0, '0, '0, 1'b0},
    '{SetThreeTerm, CoordTop, coord_t'(1), 1'b0, '0, '0, 1'b0},
    '{SetThreeTerm, UnitQ, UnitQ, 1'b0, '0, '0, 1'b0}
  };

  // Drops sh fraction bits, rounding to nearest with ties towards plus
  // infinity. The arithmetic shift floors, which is what the rounding needs.
  function automatic longint drop_frac(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp_imm(input longint v);
    if (v > ImmHi) begin
      return ImmHi;
    end
    if (v < ImmLo) begin
      return ImmLo;
    end
    return v;
  endfunction

  function automatic coord_t clamp_out(input longint v, inout logic hit);
    if (v > OutHi) begin
      hit = 1'b1;
      return coord_t'(OutHi);
    end
    if (v < OutLo) begin
      hit = 1'b1;
      return coord_t'(OutLo);
    end
    return coord_t'(v);
  endfunction

  // Distorted point under the current coefficients. Every intermediate up to
  // the scale and the tangential sums is held at 32 bits with saturation; the
  // doubled cross term 2*p*x*y is rounded once, dropping one bit fewer.
  function automatic point_out_t distort_point(input coord_t px, input coord_t py);
    longint x, y, k1, k2, k3, p1, p2;
    longint xx, yy, xy, r2, r4, r6, scale, tx, ty, xd, yd;
    point_out_t res;
    x  = px;
    y  = py;
    k1 = lens_coef[RegK1];
    k2 = lens_coef[RegK2];
    k3 = lens_coef[RegK3];
    p1 = lens_coef[RegP1];
    p2 = lens_coef[RegP2];
    xx = clamp_imm(drop_frac(x * x, FracW));
    yy = clamp_imm(drop_frac(y * y, FracW));
    xy = clamp_imm(drop_frac(x * y, FracW));
    r2 = clamp_imm(xx + yy);
    r4 = clamp_imm(drop_frac(r2 * r2, FracW));
    r6 = clamp_imm(drop_frac(r4 * r2, FracW));
    scale = clamp_imm((longint'(1) <<< FracW) + drop_frac(k1 * r2, FracW)
                      + drop_frac(k2 * r4, FracW) + drop_frac(k3 * r6, FracW));
    tx = clamp_imm(r2 + 2 * xx);
    ty = clamp_imm(r2 + 2 * yy);
    xd = drop_frac(x * scale, FracW) + drop_frac(p1 * xy, FracW - 1)
         + drop_frac(p2 * tx, FracW);
    yd = drop_frac(y * scale, FracW) + drop_frac(p2 * xy, FracW - 1)
         + drop_frac(p1 * ty, FracW);
    res.clip = 1'b0;
    res.x = clamp_out(xd, res.clip);
    res.y = clamp_out(yd, res.clip);
    return res;
  endfunction

  // Mostly points inside the usual normalised field of about +/-1.5, with a
  // share of full-range words and of the values at and next to zero and the ends.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return coord_t'($urandom);
      2: return $urandom_range(0, 1) ? CoordTop : CoordBottom;
      3: return coord_t'(int'($urandom_range(0, 2)) - 1);
      default: return coord_t'(int'($urandom_range(0, 3 * UnitInt)) - 3 * UnitInt / 2);
    endcase
  endfunction

  // A coefficient within +/-span, or, in a wild phase, now and then an
  // extreme, a zero or any word at all.
  function automatic coord_t rand_coef(input int span, input logic wild);
    if (wild) begin
      case ($urandom_range(0, 9))
        0: return coord_t'($urandom);
        1: return CoordTop;
        2: return CoordBottom;
        3: return '0;
        default: ;
      endcase
    end
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic void note_mismatch(input string what, input point_out_t want,
                                        input point_out_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s: expected x %0d y %0d clipped %0b, got x %0d y %0d clipped %0b",
               $time, what, want.x, want.y, want.clip, got.x, got.y, got.clip);
    end
  endfunction

  // Offers one point and returns at the edge where it is transferred. Valid
  // is left high so that a following point with no gap keeps it high.
  task automatic send_point(input coord_t x, input coord_t y, input logic typed,
                            input point_out_t want);
    int gap;
    gap = (idle_mode == IdleSender || idle_mode == IdleBoth) ?
          $urandom_range(0, GapMax) : 0;
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_notes.push_back('{typed: typed, want: want});
    point_ch.valid <= 1'b1;
    point_ch.x_in  <= x;
    point_ch.y_in  <= y;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input coord_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Loads a whole coefficient set. A write to an index past the last register
  // goes first; the block must ignore it.
  task automatic load_coefs(input coef_t c);
    write_reg(cfg_idx_t'(NumRegs + $urandom_range(0, (1 << CfgIdxW) - NumRegs - 1)),
              coord_t'($urandom));
    write_reg(RegK1, c.k1);
    write_reg(RegK2, c.k2);
    write_reg(RegK3, c.k3);
    write_reg(RegP1, c.p1);
    write_reg(RegP2, c.p2);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stops offering points and waits until every outstanding result has been
  // transferred, then lets the pipe run dry.
  task automatic settle();
    point_ch.valid <= 1'b0;
    while (pending_points.size() != 0 || point_notes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Every transfer on every channel is observed here, at the clock edge, on
  // the values that were stable before it. A configuration transfer updates
  // the coefficient copy; a point transfer turns into an expected result; a
  // result transfer is checked against the oldest expected one.
  always @(posedge clk) begin : scoreboard
    point_note_t note;
    point_out_t  want;
    point_out_t  got;
    logic        moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        if (cfg_ch.index < cfg_idx_t'(NumRegs)) begin
          lens_coef[cfg_ch.index] = cfg_ch.data;
        end
      end
      if (point_ch.valid && point_ch.ready) begin
        moved = 1'b1;
        note = point_notes.pop_front();
        pending_points.push_back(note.typed ? note.want :
                                 distort_point(point_ch.x_in, point_ch.y_in));
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        got = '{x: result_ch.x_out, y: result_ch.y_out, clip: result_ch.clipped};
        if (pending_points.size() == 0) begin
          note_mismatch("result with no point outstanding", '0, got);
        end else begin
          want = pending_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.clip !== want.clip) begin
            note_mismatch("wrong result", want, got);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // The result side. Before each transfer it may wait a random number of
  // cycles; once, on request, it holds ready low for a long stretch while the
  // point side keeps offering, so that the pipe fills and pushes back.
  initial begin : result_side
    int gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        result_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = (idle_mode == IdleReceiver || idle_mode == IdleBoth) ?
              $urandom_range(0, GapMax) : 0;
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // A hung handshake shows up as a long run of cycles with no transfer at all.
  initial begin : watchdog
    wait (idle_cycles >= WatchdogLimit);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    dir_row_t  row;
    coef_set_t cur_set;
    logic      wild;
    rst            <= 1'b1;
    point_ch.valid <= 1'b0;
    point_ch.x_in  <= '0;
    point_ch.y_in  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The coefficients are changed only between groups of rows,
    // once the block has delivered everything that it owes.
    cur_set = SetReset;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set != cur_set) begin
        settle();
        load_coefs(coef_sets[row.set]);
        cur_set = row.set;
      end
      send_point(row.x, row.y, row.typed, '{x: row.wx, y: row.wy, clip: row.wclip});
    end

    // Random part, in phases with fresh coefficients, the idling pattern cycling
    // through the four modes. Most phases use lens-like coefficients; every third one
    // mixes in extreme and arbitrary words. The third phase carries the long
    // hold-off on the result side, with the point side offering flat out.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      wild = (ph % 3 == 2);
      load_coefs('{k1: rand_coef(UnitInt / 2, wild), k2: rand_coef(UnitInt / 8, wild),
                   k3: rand_coef(UnitInt / 32, wild), p1: rand_coef(UnitInt / 256, wild),
                   p2: rand_coef(UnitInt / 256, wild)});
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 2) begin
        idle_mode    = IdleReceiver;
        hold_request = 1'b1;
      end
      repeat (PhaseItems) send_point(rand_coord(), rand_coord(), 1'b0, '0);
    end

    settle();
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
